// ===== src/dtdr_pkg.sv =====
// Shared types and constants for the debounced trigger delay relay.
// No dependencies; imported by every module in src.
`timescale 1ns / 1ps

package dtdr_pkg;

    // Field and register widths
    localparam int ADC_BITS     = 10;
    localparam int SAMPLE_W     = 10;
    localparam int COUNT_W      = 7;
    localparam int FILTER_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;

    // End count arithmetic: end = diff / 15 + 5, limited to the count range
    localparam int END_DIVISOR  = 15;
    localparam int END_BASE     = 5;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;

    // Reciprocal of the divisor: floor(x * RECIP >> RECIP_SHIFT) == x / 15 for x < 1024
    localparam int RECIP_SHIFT  = 15;
    localparam int RECIP        = (1 << RECIP_SHIFT) / END_DIVISOR + 1;
    localparam int RECIP_W      = RECIP_SHIFT - 3;
    localparam int PROD_W       = SAMPLE_W + RECIP_W;

    localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_ADC_OFFSET   = SAMPLE_W'(350);
    localparam logic [COUNT_W-1:0]  RST_ON_START     = COUNT_W'(5);
    localparam logic [FILTER_W-1:0] RST_DEBOUNCE_TOP = FILTER_W'(200);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_OFFSET   = 2'd0,
        CFG_ON_START     = 2'd1,
        CFG_DEBOUNCE_TOP = 2'd2
    } t_cfg_idx;

    // Debouncer status handed to the delay timer
    typedef struct packed {
        logic level;   // filtered level after this item
        logic rise;    // filtered level went from 0 to 1 with this item
    } t_dbnc_stat;

endpackage

// ===== src/dtdr_end_calc.sv =====
// End count from the knob sample: clamp at the offset, divide by 15, add 5.
// Depends on dtdr_pkg (widths and reciprocal constants).
`timescale 1ns / 1ps

module dtdr_end_calc
    import dtdr_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_adc_sample,
    input  logic [SAMPLE_W-1:0] i_adc_offset,
    output logic [COUNT_W-1:0]  o_end_count
);

    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] diff;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   quot;
    logic [PROD_W-1:0]   sum;

    // Clamp the difference at zero, then divide by reciprocal multiply
    always_comb begin
        sample = i_adc_sample & ADC_MASK;
        diff   = (sample > i_adc_offset) ? (sample - i_adc_offset) : '0;
        prod   = PROD_W'(diff) * PROD_W'(RECIP);
        quot   = prod >> RECIP_SHIFT;
        sum    = quot + PROD_W'(END_BASE);
        if (sum > PROD_W'(COUNT_MAX)) begin
            o_end_count = COUNT_W'(COUNT_MAX);
        end else begin
            o_end_count = sum[COUNT_W-1:0];
        end
    end

endmodule

// ===== src/dtdr_debounce.sv =====
// Saturating up/down integrator with hysteresis on the raw trigger pin.
// Depends on dtdr_pkg (widths, t_dbnc_stat).
`timescale 1ns / 1ps

module dtdr_debounce
    import dtdr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_pin_level,
    input  logic [FILTER_W-1:0] i_debounce_top,
    output t_dbnc_stat          o_stat
);

    logic [FILTER_W-1:0] r_filter_count;
    logic [FILTER_W-1:0] n_filter_count;
    logic                r_level;
    logic                n_level;
    logic                r_prev_level;
    logic [FILTER_W:0]   count_plus;

    // Integrate the pin, then apply high and low thresholds (low wins)
    always_comb begin
        n_filter_count = r_filter_count;
        if (i_pin_level) begin
            if (r_filter_count < i_debounce_top) begin
                n_filter_count = r_filter_count + 1'b1;
            end
        end else if (r_filter_count != '0) begin
            n_filter_count = r_filter_count - 1'b1;
        end
        // count >= top - 1 is count + 1 >= top without going negative
        count_plus = {1'b0, n_filter_count} + 1'b1;
        n_level    = r_level;
        if (count_plus >= {1'b0, i_debounce_top}) begin
            n_level = 1'b1;
        end
        if (n_filter_count <= FILTER_W'(1)) begin
            n_level = 1'b0;
        end
        o_stat.level = n_level;
        o_stat.rise  = n_level & ~r_prev_level;
    end

    // Advance the filter state on each transfer into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_count <= '0;
            r_level        <= 1'b0;
            r_prev_level   <= 1'b0;
        end else if (i_step) begin
            r_filter_count <= n_filter_count;
            r_level        <= n_level;
            r_prev_level   <= n_level;
        end
    end

endmodule

// ===== src/debounced_trigger_delay_relay.sv =====
// Top level: input register, delay timer, result register and config registers.
// Depends on dtdr_pkg, dtdr_end_calc and dtdr_debounce.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-----------------------------------------
//  input    | i_valid   | o_stall   | i_tick, i_pin_level, i_adc_sample
//  result   | o_valid   | i_stall   | o_relay_on, o_input_debounced
//  config   | i_cfg_we  | (none)    | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while i_stall is low; an item goes from the input
// register to the result register once that is empty or being taken.
// The state update and end count divide sit between the input and result
// registers. Synchronous active-low reset clears control and state; the
// config registers return to 350 / 5 / 200. A stalled result holds its value
// while the input register keeps one more item, then o_stall rises.
`timescale 1ns / 1ps

module debounced_trigger_delay_relay
    import dtdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_tick,
    input  logic                  i_pin_level,
    input  logic [SAMPLE_W-1:0]   i_adc_sample,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_relay_on,
    output logic                  o_input_debounced,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SAMPLE_W-1:0] r_adc_offset;
    logic [COUNT_W-1:0]  r_on_start;
    logic [FILTER_W-1:0] r_debounce_top;

    logic                r_in_valid;
    logic                r_tick;
    logic                r_pin_level;
    logic [SAMPLE_W-1:0] r_adc_sample;

    logic                r_out_valid;
    logic                r_out_relay;
    logic                r_out_debounced;

    logic [COUNT_W-1:0]  r_delay_count;
    logic [COUNT_W-1:0]  n_delay_count;
    logic                r_relay_level;
    logic                n_relay_level;

    logic                step;
    logic [COUNT_W-1:0]  end_count;
    logic [COUNT_W-1:0]  count_inc;
    t_dbnc_stat          dbnc_stat;

    // Handshake: advance when the result register is empty or being taken
    assign step    = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_in_valid & ~step;
    assign o_valid = r_out_valid;
    assign o_relay_on        = r_out_relay;
    assign o_input_debounced = r_out_debounced;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_offset   <= RST_ADC_OFFSET;
            r_on_start     <= RST_ON_START;
            r_debounce_top <= RST_DEBOUNCE_TOP;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ADC_OFFSET:   r_adc_offset   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ON_START:     r_on_start     <= i_cfg_data[COUNT_W-1:0];
                CFG_DEBOUNCE_TOP: r_debounce_top <= i_cfg_data[FILTER_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture a transfer into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_tick       <= i_tick;
            r_pin_level  <= i_pin_level;
            r_adc_sample <= i_adc_sample;
        end
    end

    dtdr_end_calc u_end_calc (
        .i_adc_sample (r_adc_sample),
        .i_adc_offset (r_adc_offset),
        .o_end_count  (end_count)
    );

    dtdr_debounce u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_pin_level    (r_pin_level),
        .i_debounce_top (r_debounce_top),
        .o_stat         (dbnc_stat)
    );

    // Step the delay count on a tick, recompute the relay, then edge start
    always_comb begin
        n_delay_count = r_delay_count;
        n_relay_level = r_relay_level;
        count_inc     = r_delay_count + 1'b1;
        if (r_tick) begin
            if (r_delay_count != '0 && r_delay_count < end_count) begin
                n_delay_count = (count_inc >= end_count) ? '0 : count_inc;
            end
            n_relay_level = (n_delay_count >= r_on_start) && (n_delay_count <= end_count);
        end
        if (dbnc_stat.rise && n_delay_count == '0) begin
            n_delay_count = COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_count <= '0;
            r_relay_level <= 1'b0;
        end else if (step) begin
            r_delay_count <= n_delay_count;
            r_relay_level <= n_relay_level;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_relay     <= n_relay_level;
            r_out_debounced <= dbnc_stat.level;
        end
    end

`ifndef SYNTH
    // A non-tick item leaves the relay level alone
    a_relay_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && !r_tick |=> r_relay_level == $past(r_relay_level))
        else $error("relay level changed on a non-tick item");

    // An idle count only ever starts at one
    a_count_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_delay_count == '0 |=> r_delay_count <= COUNT_W'(1))
        else $error("delay count left idle at a value other than one");

    // Back-pressure only with an item waiting in the input register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without a waiting result");

    // The timer state does not move without a transfer into the result stage
    a_state_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_delay_count))
        else $error("delay count moved without an item");
`endif

endmodule

// ===== tb/dtdr_relay_checker.sv =====
// Scoreboard for the debounced trigger delay relay: tracks config writes,
// predicts relay and debounced levels per input transfer, checks result transfers.
// Depends on dtdr_pkg.
`timescale 1ns / 1ps

module dtdr_relay_checker
    import dtdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel as seen at the block
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_tick,
    input  logic                  i_pin_level,
    input  logic [SAMPLE_W-1:0]   i_adc_sample,
    // result channel as seen at the block
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_relay_on,
    input  logic                  i_input_debounced,
    // configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // status for the testbench top
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic relay_on;
        logic input_debounced;
    } t_relay_levels;

    t_relay_levels expected_levels[$];
    t_relay_levels want;

    // shadow configuration
    logic [SAMPLE_W-1:0] adc_offset;
    logic [COUNT_W-1:0]  on_start;
    logic [FILTER_W-1:0] debounce_top;

    // predicted timer and debouncer state
    logic [FILTER_W-1:0] filt_count;
    logic                filt_level;
    logic                last_level;
    logic [COUNT_W-1:0]  delay_count;
    logic                relay_level;

    logic [SAMPLE_W-1:0] masked_sample;
    int                  sample_diff;
    int                  end_cnt;
    int                  hi_thresh;
    int                  mismatches = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            adc_offset   = RST_ADC_OFFSET;
            on_start     = RST_ON_START;
            debounce_top = RST_DEBOUNCE_TOP;
            filt_count   = '0;
            filt_level   = 1'b0;
            last_level   = 1'b0;
            delay_count  = '0;
            relay_level  = 1'b0;
            expected_levels.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ADC_OFFSET:   adc_offset   = i_cfg_data[SAMPLE_W-1:0];
                    CFG_ON_START:     on_start     = i_cfg_data[COUNT_W-1:0];
                    CFG_DEBOUNCE_TOP: debounce_top = i_cfg_data[FILTER_W-1:0];
                    default: ;
                endcase
            end

            // check a result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_levels.size() == 0) begin
                    $error("result transfer with no input item outstanding");
                    mismatches++;
                end else begin
                    want = expected_levels.pop_front();
                    if (i_relay_on !== want.relay_on) begin
                        $error("relay_on: expected %0b, actual %0b",
                               want.relay_on, i_relay_on);
                        mismatches++;
                    end
                    if (i_input_debounced !== want.input_debounced) begin
                        $error("input_debounced: expected %0b, actual %0b",
                               want.input_debounced, i_input_debounced);
                        mismatches++;
                    end
                end
            end

            // advance the predicted state for an input transfer
            if (i_in_valid && !i_in_stall) begin
                // timer step on a tick
                if (i_tick) begin
                    masked_sample = i_adc_sample & ADC_MASK;
                    sample_diff = (masked_sample > adc_offset) ?
                                  int'(masked_sample) - int'(adc_offset) : 0;
                    end_cnt = sample_diff / END_DIVISOR + END_BASE;
                    if (end_cnt > COUNT_MAX)
                        end_cnt = COUNT_MAX;
                    if (delay_count != 0 && int'(delay_count) < end_cnt) begin
                        delay_count = delay_count + 1'b1;
                        if (int'(delay_count) >= end_cnt)
                            delay_count = '0;
                    end
                    relay_level = (delay_count >= on_start) && (int'(delay_count) <= end_cnt);
                end

                // integrate the pin, then apply hysteresis; low threshold wins
                if (i_pin_level) begin
                    if (filt_count < debounce_top)
                        filt_count = filt_count + 1'b1;
                end else if (filt_count != 0) begin
                    filt_count = filt_count - 1'b1;
                end
                hi_thresh = int'(debounce_top) - 1;
                if (int'(filt_count) >= hi_thresh)
                    filt_level = 1'b1;
                if (filt_count <= 1)
                    filt_level = 1'b0;

                // start the count on a debounced rise while idle
                if (filt_level && !last_level && delay_count == 0)
                    delay_count = COUNT_W'(1);
                last_level = filt_level;

                expected_levels.push_back('{relay_on: relay_level,
                                            input_debounced: filt_level});
            end
        end
        o_pending    <= expected_levels.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_debounced_trigger_delay_relay.sv =====
// Testbench top for debounced_trigger_delay_relay: drives directed and random
// items with random gaps and stalls; dtdr_relay_checker does the checking.
// Depends on dtdr_pkg, debounced_trigger_delay_relay and dtdr_relay_checker.
`timescale 1ns / 1ps

module tb_debounced_trigger_delay_relay;
    import dtdr_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int NUM_PHASES  = 9;
    localparam int DRAIN_CYCLES = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_tick;
    logic                  i_pin_level;
    logic [SAMPLE_W-1:0]   i_adc_sample;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_relay_on;
    logic                  o_input_debounced;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_calm   = 0;
    int recv_calm   = 0;
    int top_now     = 200;
    int offset_now  = 350;

    // random phases: offset, on_start, debounce_top, item count
    int phase_offset[NUM_PHASES] = '{350,   0, 1023, 200, 500,   0, 100, 100, 700};
    int phase_start [NUM_PHASES] = '{  5,   0,  127,  10,   3,  40,   1,   1,   0};
    int phase_top   [NUM_PHASES] = '{200,   3,  255,   8,   2,  12,  20,   4,   1};
    int phase_items [NUM_PHASES] = '{260, 200,  280, 250, 200, 250, 200, 150,  60};

    debounced_trigger_delay_relay i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_tick            (i_tick),
        .i_pin_level       (i_pin_level),
        .i_adc_sample      (i_adc_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_relay_on        (o_relay_on),
        .o_input_debounced (o_input_debounced),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    dtdr_relay_checker u_relay_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_tick            (i_tick),
        .i_pin_level       (i_pin_level),
        .i_adc_sample      (i_adc_sample),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_relay_on        (o_relay_on),
        .i_input_debounced (o_input_debounced),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // wait count per transfer: calm stretches of zero, otherwise zero or a random wait
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = int'($urandom_range(20, 60));
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return int'($urandom_range(0, 14));
    endfunction

    // present one item after a random gap and hold it until transferred
    task automatic send_item(input logic tick, input logic pin,
                             input logic [SAMPLE_W-1:0] sample);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_tick       <= tick;
        i_pin_level  <= pin;
        i_adc_sample <= sample;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid and wait for every outstanding result plus pipeline slack
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers once the block is idle
    task automatic apply_settings(input logic [SAMPLE_W-1:0] offset,
                                  input logic [COUNT_W-1:0] start,
                                  input logic [FILTER_W-1:0] top);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ADC_OFFSET;
        i_cfg_data <= CFG_DATA_W'(offset);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ON_START;
        i_cfg_data <= CFG_DATA_W'(start);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DEBOUNCE_TOP;
        i_cfg_data <= CFG_DATA_W'(top);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        top_now    = int'(top);
        offset_now = int'(offset);
    endtask

    // result side: random stall before each transfer
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            hold = draw_wait(recv_calm);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // stimulus
    initial begin
        int                  run_left;
        int                  tick_div;
        int                  pick;
        int                  near;
        logic                pin_now;
        logic                pin;
        logic                tick;
        logic [SAMPLE_W-1:0] sample;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_tick       = 1'b0;
        i_pin_level  = 1'b0;
        i_adc_sample = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_ADC_OFFSET;
        i_cfg_data   = '0;
        run_left     = 0;
        pin_now      = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: sample below, at and above the offset, and ignored off tick
        send_item(1'b1, 1'b0, 10'd0);
        send_item(1'b1, 1'b1, 10'd1023);
        send_item(1'b0, 1'b0, 10'd1023);
        send_item(1'b0, 1'b1, 10'd0);
        send_item(1'b1, 1'b1, 10'd350);
        send_item(1'b1, 1'b1, 10'd365);

        // zero start and a top of two: relay on while idle, quick rise, full count
        apply_settings(10'd0, 7'd0, 8'd2);
        send_item(1'b1, 1'b0, 10'd0);
        send_item(1'b0, 1'b1, 10'd0);
        send_item(1'b0, 1'b1, 10'd0);
        repeat (4) send_item(1'b1, 1'b1, 10'd0);
        send_item(1'b0, 1'b0, 10'd0);
        send_item(1'b0, 1'b1, 10'd1023);
        send_item(1'b1, 1'b0, 10'd1023);

        // top of one and zero: thresholds at 0 and -1, largest start and offset
        apply_settings(10'd1023, 7'd127, 8'd1);
        send_item(1'b1, 1'b1, 10'd1023);
        send_item(1'b1, 1'b1, 10'd0);
        send_item(1'b0, 1'b0, 10'd512);
        apply_settings(10'd0, 7'd0, 8'd0);
        send_item(1'b1, 1'b1, 10'd1023);
        send_item(1'b0, 1'b0, 10'd0);
        send_item(1'b1, 1'b0, 10'd1023);

        // random phases: pin held in runs around the top so the debouncer toggles
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apply_settings(SAMPLE_W'(phase_offset[ph]), COUNT_W'(phase_start[ph]),
                           FILTER_W'(phase_top[ph]));
            tick_div = int'($urandom_range(0, 3));
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (run_left == 0) begin
                    pin_now = !pin_now;
                    if ($urandom_range(0, 9) < 7)
                        run_left = int'($urandom_range(top_now + 1, top_now + 6));
                    else
                        run_left = int'($urandom_range(1, top_now + 1));
                end
                run_left--;
                pin = pin_now;
                if ($urandom_range(0, 19) == 0)
                    pin = !pin;

                tick = ($urandom_range(0, tick_div) == 0);

                pick = int'($urandom_range(0, 9));
                if (pick < 6) begin
                    sample = SAMPLE_W'($urandom_range(0, 1023));
                end else if (pick < 8) begin
                    near = offset_now + int'($urandom_range(0, 40)) - 5;
                    if (near < 0)
                        near = 0;
                    if (near > 1023)
                        near = 1023;
                    sample = SAMPLE_W'(near);
                end else if (pick == 8) begin
                    sample = '0;
                end else begin
                    sample = '1;
                end

                send_item(tick, pin, sample);
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
